>>> src/bb3_pkg.sv
// Shared types, codes and the reciprocal table for the 3x3 box blur.
`default_nettype none

package bb3_pkg;

	// Item kinds on the pixel channel.
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// Configuration register indexes.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam int CFG_INDEX_W    = 1;
	localparam int CFG_DATA_W     = 13;
	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;

	// Neighborhood sum of up to nine 8-bit values, and the pixel count.
	localparam int SUM_W       = 12;
	localparam int NUM_W       = SUM_W + 1;
	localparam int COUNT_W     = 4;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 20;

	typedef struct packed {
		logic       func;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pixel_beat_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} result_beat_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// One column of the line store: the pixel one row up and two rows up.
	typedef struct packed {
		rgb_t prev;
		rgb_t older;
	} line_entry_t;

	// Which parts of the 3x3 window lie inside the frame, and output marks.
	typedef struct packed {
		logic emit;
		logic last;
		logic top;
		logic bottom;
		logic left;
		logic right;
	} win_ctrl_t;

	typedef struct packed {
		logic               emit;
		logic               last;
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   red;
		logic [SUM_W-1:0]   green;
		logic [SUM_W-1:0]   blue;
	} win_sums_t;

	// ceil(2^20 / (2*count)); exact floor division for numerators below 8192.
	function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
		logic [RECIP_W-1:0] m;
		case (count)
			4'd1:    m = 20'd524288;
			4'd2:    m = 20'd262144;
			4'd3:    m = 20'd174763;
			4'd4:    m = 20'd131072;
			4'd6:    m = 20'd87382;
			4'd9:    m = 20'd58255;
			default: m = 20'd524288;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

>>> src/bb3_line_store.sv
// Two line stores in one memory, with read-after-write forwarding.
`default_nettype none

module bb3_line_store #(
	parameter  int DEPTH = 1024,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    rd_en,
	input  wire logic [AW-1:0]           rd_addr,
	input  wire logic                    wr_en,
	input  wire logic [AW-1:0]           wr_addr,
	input  wire bb3_pkg::line_entry_t    wr_data,
	output bb3_pkg::line_entry_t         rd_data
);

	bb3_pkg::line_entry_t mem_q [DEPTH];
	bb3_pkg::line_entry_t rd_q;
	bb3_pkg::line_entry_t fwd_data_q;
	logic                 fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem_q[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// A read that meets a write to the same column sees the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

>>> src/bb3_window.sv
// 3x3 window registers and the masked neighborhood sums.
`default_nettype none

module bb3_window (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                shift,
	input  wire bb3_pkg::rgb_t       top_px,
	input  wire bb3_pkg::rgb_t       mid_px,
	input  wire bb3_pkg::rgb_t       bot_px,
	input  wire bb3_pkg::win_ctrl_t  ctrl_s1,
	output bb3_pkg::win_sums_t       sums_s3
);

	// Column 0 is the newest (right), column 2 the oldest (left); row 0 is top.
	bb3_pkg::rgb_t      win_q [3][3];
	bb3_pkg::win_ctrl_t ctrl_s2;
	bb3_pkg::win_sums_t sums_d;
	logic [2:0]         row_ok;
	logic [2:0]         col_ok;
	logic [1:0]         rows_n;
	logic [1:0]         cols_n;

	always_ff @(posedge clk) begin
		if (shift) begin
			win_q[2]    <= win_q[1];
			win_q[1]    <= win_q[0];
			win_q[0][0] <= top_px;
			win_q[0][1] <= mid_px;
			win_q[0][2] <= bot_px;
		end
	end

	always_comb begin
		row_ok = {ctrl_s2.bottom, 1'b1, ctrl_s2.top};
		col_ok = {ctrl_s2.left, 1'b1, ctrl_s2.right};
		rows_n = 2'd1 + 2'(ctrl_s2.top) + 2'(ctrl_s2.bottom);
		cols_n = 2'd1 + 2'(ctrl_s2.left) + 2'(ctrl_s2.right);
		sums_d       = '0;
		sums_d.emit  = ctrl_s2.emit;
		sums_d.last  = ctrl_s2.last;
		sums_d.count = {2'b00, rows_n} * {2'b00, cols_n};
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (col_ok[c] && row_ok[r]) begin
					sums_d.red   = sums_d.red   + bb3_pkg::SUM_W'(win_q[c][r].red);
					sums_d.green = sums_d.green + bb3_pkg::SUM_W'(win_q[c][r].green);
					sums_d.blue  = sums_d.blue  + bb3_pkg::SUM_W'(win_q[c][r].blue);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			sums_s3 <= '0;
		end else if (adv) begin
			ctrl_s2 <= ctrl_s1;
			sums_s3 <= sums_d;
		end
	end

endmodule

`default_nettype wire

>>> src/bb3_avg.sv
// Rounded average (2*sum+count)/(2*count) per channel by reciprocal multiply.
`default_nettype none

module bb3_avg (
	input  wire bb3_pkg::win_sums_t sums,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue
);

	localparam int PROD_W = bb3_pkg::NUM_W + bb3_pkg::RECIP_W;

	logic [bb3_pkg::RECIP_W-1:0] m;

	function automatic logic [7:0] chan_avg(
		input logic [bb3_pkg::SUM_W-1:0]   sum,
		input logic [bb3_pkg::COUNT_W-1:0] cnt,
		input logic [bb3_pkg::RECIP_W-1:0] mul
	);
		logic [bb3_pkg::NUM_W-1:0] num;
		logic [PROD_W-1:0]         prod;
		num  = {sum, 1'b0} + bb3_pkg::NUM_W'(cnt);
		prod = PROD_W'(num) * PROD_W'(mul);
		return prod[bb3_pkg::RECIP_SHIFT +: 8];
	endfunction

	assign m     = bb3_pkg::recip(sums.count);
	assign red   = chan_avg(sums.red, sums.count, m);
	assign green = chan_avg(sums.green, sums.count, m);
	assign blue  = chan_avg(sums.blue, sums.count, m);

endmodule

`default_nettype wire

>>> src/box_blur_3x3_core.sv
// Streaming 3x3 box blur: position control, line store, window, divide, output.
// An item is registered at the input, in the window, in the sums and at the output.
// One item per cycle while the output does not stall, set by the line store's one read and
// one write per cycle; after the last pixel of a one-row frame the input stalls for one step.
// Reset clears positions and the frame state, sets width min(MAX_WIDTH, 1024) and height 1;
// the line store is not cleared.
`default_nettype none

module box_blur_3x3_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bb3_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               pixel_valid,
	output logic                                    pixel_stall,
	input  wire bb3_pkg::pixel_beat_t               pixel_data,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output bb3_pkg::result_beat_t                   result_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 3);
	localparam int OW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [AW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [AW-1:0] out_col_q;
	logic [OW-1:0] out_row_q;
	logic          input_done_q;
	logic          bubble_q;

	logic [WW-1:0] width_new;
	logic [HW-1:0] height_new;
	logic [bb3_pkg::FRAME_WIDTH_W-1:0]  cfg_w;
	logic [bb3_pkg::FRAME_HEIGHT_W-1:0] cfg_h;

	logic adv, acc, is_pix, is_drain, bubble_go, push, emit, frame_end;
	logic in_col_last, in_row_last, out_col_last, out_row_last, pix_emit_ok;

	logic                 vld_s1;
	logic [AW-1:0]        col_s1;
	bb3_pkg::rgb_t        pix_s1;
	bb3_pkg::win_ctrl_t   ctrl_s1;
	bb3_pkg::win_ctrl_t   ctrl_d;

	bb3_pkg::line_entry_t rd_data;
	bb3_pkg::line_entry_t wr_data;
	bb3_pkg::win_sums_t   sums_s3;
	logic [7:0]           avg_red, avg_green, avg_blue;

	logic                  result_valid_q;
	bb3_pkg::result_beat_t result_data_q;

	// Register values out of range saturate.
	always_comb begin
		cfg_w = cfg_data[bb3_pkg::FRAME_WIDTH_W-1:0];
		cfg_h = cfg_data[bb3_pkg::FRAME_HEIGHT_W-1:0];
		if (cfg_w == '0) begin
			width_new = WW'(1);
		end else if (32'(cfg_w) > MAX_WIDTH) begin
			width_new = WW'(MAX_WIDTH);
		end else begin
			width_new = WW'(cfg_w);
		end
		if (cfg_h == '0) begin
			height_new = HW'(1);
		end else if (32'(cfg_h) > MAX_HEIGHT) begin
			height_new = HW'(MAX_HEIGHT);
		end else begin
			height_new = HW'(cfg_h);
		end
	end

	assign adv         = !result_valid_q || !result_stall;
	assign pixel_stall = !adv || bubble_q;
	assign acc         = pixel_valid && !pixel_stall;
	assign is_pix      = acc && (pixel_data.func == bb3_pkg::FUNC_PIXEL) && !input_done_q;
	assign is_drain    = acc && (pixel_data.func == bb3_pkg::FUNC_DRAIN) && input_done_q;
	assign bubble_go   = bubble_q && adv;
	assign push        = is_pix || is_drain || bubble_go;

	assign in_col_last  = 32'(in_col_q) == 32'(width_q) - 32'd1;
	assign in_row_last  = 32'(in_row_q) == 32'(height_q) - 32'd1;
	assign out_col_last = 32'(out_col_q) == 32'(width_q) - 32'd1;
	assign out_row_last = 32'(out_row_q) == 32'(height_q) - 32'd1;

	// A pixel releases an output once it lies one row and one column past it.
	assign pix_emit_ok = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
	assign emit        = (is_pix && pix_emit_ok) || is_drain;
	assign frame_end   = is_drain && out_row_last && out_col_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= WW'(WIDTH_RST);
			height_q     <= HW'(1);
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			input_done_q <= 1'b0;
			bubble_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bb3_pkg::REG_FRAME_WIDTH:  width_q  <= width_new;
				bb3_pkg::REG_FRAME_HEIGHT: height_q <= height_new;
				default: ;
			endcase
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			input_done_q <= 1'b0;
			bubble_q     <= 1'b0;
		end else begin
			// Input positions keep running through drain beats so the window
			// keeps its fixed lag behind the output position.
			if (push) begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
			end
			// A one-row frame is one pixel short of that lag, so one internal
			// step is inserted after its last pixel.
			if (is_pix && in_row_last && in_col_last) begin
				input_done_q <= 1'b1;
				if (height_q == HW'(1)) begin
					bubble_q <= 1'b1;
				end
			end
			if (bubble_go) begin
				bubble_q <= 1'b0;
			end
			if (emit) begin
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + OW'(1);
				end else begin
					out_col_q <= out_col_q + AW'(1);
				end
			end
			if (frame_end) begin
				in_col_q     <= '0;
				in_row_q     <= '0;
				out_col_q    <= '0;
				out_row_q    <= '0;
				input_done_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctrl_d        = '0;
		ctrl_d.emit   = emit;
		ctrl_d.last   = out_row_last && out_col_last;
		ctrl_d.top    = out_row_q != '0;
		ctrl_d.bottom = !out_row_last;
		ctrl_d.left   = out_col_q != '0;
		ctrl_d.right  = !out_col_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			ctrl_s1 <= '0;
		end else if (adv) begin
			vld_s1  <= push;
			ctrl_s1 <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			col_s1       <= in_col_q;
			pix_s1.red   <= pixel_data.red_in;
			pix_s1.green <= pixel_data.green_in;
			pix_s1.blue  <= pixel_data.blue_in;
		end
	end

	// The new pixel becomes the row above; the old row above moves down one.
	always_comb begin
		wr_data.prev  = pix_s1;
		wr_data.older = rd_data.prev;
	end

	bb3_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (push),
		.rd_addr (in_col_q),
		.wr_en   (adv && vld_s1),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	bb3_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.shift   (adv && vld_s1),
		.top_px  (rd_data.older),
		.mid_px  (rd_data.prev),
		.bot_px  (pix_s1),
		.ctrl_s1 (ctrl_s1),
		.sums_s3 (sums_s3)
	);

	bb3_avg u_avg (
		.sums  (sums_s3),
		.red   (avg_red),
		.green (avg_green),
		.blue  (avg_blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= sums_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_data_q.red_out    <= avg_red;
			result_data_q.green_out  <= avg_green;
			result_data_q.blue_out   <= avg_blue;
			result_data_q.frame_last <= sums_s3.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_data_q;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the streaming 3x3 box blur core.
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_W         = 1024;
	localparam int MAX_H         = 4096;
	localparam int HIST_DEPTH    = 2 * MAX_W + 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 650;

	// Tracks the frame geometry and pixel history, predicts every blurred pixel
	// and checks the block's results against them in order.
	class blur_checker;
		logic [bb3_pkg::FRAME_WIDTH_W-1:0]  width_reg;
		logic [bb3_pkg::FRAME_HEIGHT_W-1:0] height_reg;
		bit [23:0]             history [HIST_DEPTH];
		int                    in_col, in_row, out_col, out_row;
		bit                    input_done;
		bb3_pkg::result_beat_t expected_pixels [$];
		int                    errors, checked, frames;

		function new();
			width_reg = 11'd1024;
			height_reg = 13'd1;
			foreach (history[i]) history[i] = '0;
			errors = 0;
			checked = 0;
			frames = 0;
			restart();
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			input_done = 1'b0;
		endfunction

		function void write_reg(logic idx, logic [bb3_pkg::CFG_DATA_W-1:0] val);
			if (idx == bb3_pkg::REG_FRAME_WIDTH) width_reg = val[bb3_pkg::FRAME_WIDTH_W-1:0];
			else height_reg = val[bb3_pkg::FRAME_HEIGHT_W-1:0];
			restart();
		endfunction

		function int eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return int'(width_reg);
		endfunction

		function int eff_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_H) return MAX_H;
			return int'(height_reg);
		endfunction

		// Averages the clipped neighborhood of the next output position, then advances it.
		function bb3_pkg::result_beat_t blur_next(int w, int h);
			int sr, sg, sb, cnt, rr, cc;
			bit [23:0] px;
			bb3_pkg::result_beat_t res;
			sr = 0;
			sg = 0;
			sb = 0;
			cnt = 0;
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					rr = out_row + dr;
					cc = out_col + dc;
					if (rr < 0 || cc < 0 || rr >= h || cc >= w) continue;
					px = history[(rr * w + cc) % HIST_DEPTH];
					sr += px[23:16];
					sg += px[15:8];
					sb += px[7:0];
					cnt++;
				end
			end
			res.red_out = 8'((2 * sr + cnt) / (2 * cnt));
			res.green_out = 8'((2 * sg + cnt) / (2 * cnt));
			res.blue_out = 8'((2 * sb + cnt) / (2 * cnt));
			res.frame_last = (out_row == h - 1 && out_col == w - 1);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
			return res;
		endfunction

		function void note_input(bb3_pkg::pixel_beat_t b);
			int w, h, k;
			bb3_pkg::result_beat_t res;
			w = eff_width();
			h = eff_height();
			if (b.func == bb3_pkg::FUNC_PIXEL) begin
				if (input_done) return;
				k = in_row * w + in_col;
				history[k % HIST_DEPTH] = {b.red_in, b.green_in, b.blue_in};
				in_col++;
				if (in_col >= w) begin
					in_col = 0;
					in_row++;
				end
				if (k == w * h - 1) input_done = 1'b1;
				if (k >= w + 1) expected_pixels.push_back(blur_next(w, h));
			end else if (input_done) begin
				res = blur_next(w, h);
				expected_pixels.push_back(res);
				if (res.frame_last) begin
					frames++;
					restart();
				end
			end
		endfunction

		function void report_field(string name, int exp_v, int got_v);
			if (exp_v != got_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			end
		endfunction

		function void check_result(bb3_pkg::result_beat_t got);
			bb3_pkg::result_beat_t exp_px;
			if (expected_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				return;
			end
			exp_px = expected_pixels.pop_front();
			checked++;
			report_field("red_out", exp_px.red_out, got.red_out);
			report_field("green_out", exp_px.green_out, got.green_out);
			report_field("blue_out", exp_px.blue_out, got.blue_out);
			report_field("frame_last", exp_px.frame_last, got.frame_last);
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            pixel_valid;
	logic                            pixel_stall;
	bb3_pkg::pixel_beat_t            pixel_data;
	logic                            result_valid;
	logic                            result_stall;
	bb3_pkg::result_beat_t           result_data;

	blur_checker sb = new();

	bit burst;
	bit hold_req;
	int items_counted;
	int frames_aborted;
	int cfg_writes;

	always #2 clk = ~clk;

	box_blur_3x3_core #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_data(pixel_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

	function automatic int pick_gap();
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 97) return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [7:0] rand_channel();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic bb3_pkg::pixel_beat_t make_pixel();
		bb3_pkg::pixel_beat_t p;
		p.func = bb3_pkg::FUNC_PIXEL;
		p.red_in = rand_channel();
		p.green_in = rand_channel();
		p.blue_in = rand_channel();
		return p;
	endfunction

	function automatic bb3_pkg::pixel_beat_t make_drain();
		bb3_pkg::pixel_beat_t p;
		p.func = bb3_pkg::FUNC_DRAIN;
		p.red_in = 8'($urandom);
		p.green_in = 8'($urandom);
		p.blue_in = 8'($urandom);
		return p;
	endfunction

	// Valid stays high after a beat so that back-to-back beats need no extra edge.
	task automatic send_beat(input bb3_pkg::pixel_beat_t b, input int gap);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_data <= b;
		@(posedge clk);
		while (pixel_stall !== 1'b0) @(posedge clk);
		sb.note_input(b);
	endtask

	task automatic cfg_write(input logic idx, input logic [bb3_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		cfg_writes++;
		@(posedge clk);
	endtask

	// Waits until every predicted pixel has come out and the pipeline is empty.
	task automatic settle();
		pixel_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sends keep pixels of a w by h frame with some ignored noise; a full frame is drained.
	task automatic run_frame(input int w, input int h, input int keep, input int hold_at);
		int total, drains;
		total = w * h;
		for (int i = 0; i < keep; i++) begin
			if ($urandom_range(0, 29) == 0) send_beat(make_drain(), pick_gap());
			if (i == hold_at) hold_req = 1'b1;
			send_beat(make_pixel(), pick_gap());
			items_counted++;
		end
		if (keep < total) begin
			frames_aborted++;
			return;
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) send_beat(make_pixel(), pick_gap());
		end
		drains = (total < w + 1) ? total : w + 1;
		repeat (drains) send_beat(make_drain(), pick_gap());
		items_counted += drains;
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_result(result_data);
	end

	// Receiver side: random stalls, stretches without any, and one long hold-off on request.
	initial begin
		int r, n;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					result_stall <= 1'b0;
					n = $urandom_range(1, 20);
				end else if (r < 95) begin
					result_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else begin
					result_stall <= 1'b1;
					n = $urandom_range(10, 40);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		#6_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		bb3_pkg::pixel_beat_t p;
		int w, h, total, keep;
		bit need_cfg;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pixel_valid <= 1'b0;
		pixel_data <= '0;
		burst = 1'b0;
		hold_req = 1'b0;
		items_counted = 0;
		frames_aborted = 0;
		cfg_writes = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry is 1024 by 1: an early drain is ignored, a few pixels emit nothing.
		send_beat(make_drain(), pick_gap());
		repeat (3) send_beat(make_pixel(), pick_gap());
		settle();

		// Zero registers saturate to a single pixel frame.
		cfg_write(bb3_pkg::REG_FRAME_WIDTH, '0);
		cfg_write(bb3_pkg::REG_FRAME_HEIGHT, '0);
		p = '{func: bb3_pkg::FUNC_PIXEL, red_in: 8'hFF, green_in: 8'hFF, blue_in: 8'hFF};
		send_beat(p, 0);
		// Pixel after the frame has ended is dropped.
		p = '{func: bb3_pkg::FUNC_PIXEL, red_in: 8'h00, green_in: 8'h00, blue_in: 8'h00};
		send_beat(p, pick_gap());
		send_beat(make_drain(), pick_gap());
		// Drain before the next frame has ended is dropped.
		send_beat(make_drain(), pick_gap());
		settle();

		// 3x3 checkerboard: corners average to exact halves and must round up.
		cfg_write(bb3_pkg::REG_FRAME_WIDTH, 13'd3);
		cfg_write(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
		for (int i = 0; i < 9; i++) begin
			p.func = bb3_pkg::FUNC_PIXEL;
			p.red_in = (i % 2 == 0) ? 8'hFF : 8'h00;
			p.green_in = ~p.red_in;
			p.blue_in = 8'(i * 29);
			send_beat(p, pick_gap());
		end
		repeat (4) send_beat(make_drain(), pick_gap());
		settle();

		// Oversized height saturates; the frame is cut short by the next write.
		cfg_write(bb3_pkg::REG_FRAME_WIDTH, 13'd2);
		cfg_write(bb3_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
		repeat (6) send_beat(make_pixel(), pick_gap());
		frames_aborted++;
		settle();

		// A long output hold-off in the middle of a burst fills the block and stalls its input.
		cfg_write(bb3_pkg::REG_FRAME_WIDTH, 13'd24);
		cfg_write(bb3_pkg::REG_FRAME_HEIGHT, 13'd6);
		burst = 1'b1;
		run_frame(sb.eff_width(), sb.eff_height(), sb.eff_width() * sb.eff_height(), 60);
		burst = 1'b0;
		settle();

		items_counted = 0;
		need_cfg = 1'b1;
		while (items_counted < RANDOM_ITEMS) begin
			if (need_cfg || $urandom_range(0, 2) != 0) begin
				settle();
				r_width: begin
					int r;
					r = $urandom_range(0, 99);
					w = (r < 85) ? $urandom_range(1, 10) : (r < 97) ? $urandom_range(11, 48) : 0;
					r = $urandom_range(0, 99);
					h = (r < 85) ? $urandom_range(1, 5) : (r < 97) ? $urandom_range(6, 16) : 0;
				end
				case ($urandom_range(0, 3))
					0: cfg_write(bb3_pkg::REG_FRAME_WIDTH, 13'(w));
					1: cfg_write(bb3_pkg::REG_FRAME_HEIGHT, 13'(h));
					default: begin
						cfg_write(bb3_pkg::REG_FRAME_WIDTH, 13'(w));
						cfg_write(bb3_pkg::REG_FRAME_HEIGHT, 13'(h));
					end
				endcase
			end
			w = sb.eff_width();
			h = sb.eff_height();
			total = w * h;
			keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
			burst = ($urandom_range(0, 3) == 0);
			run_frame(w, h, keep, -1);
			burst = 1'b0;
			need_cfg = (keep < total);
		end
		settle();

		$display("Run covered %0d complete frames and %0d cut short, %0d register writes,",
			sb.frames, frames_aborted, cfg_writes);
		$display("and %0d blurred pixels compared, on frames from a single pixel to 48-pixel lines.",
			sb.checked);
		if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> sim.f
src/bb3_pkg.sv
src/bb3_line_store.sv
src/bb3_window.sv
src/bb3_avg.sv
src/box_blur_3x3_core.sv
tb/sv/testbench.sv
